// ===== rtl/core/wpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types, constants and the quarter-wave sine entry function for the
// two-pole wave displacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpd_pkg;

  localparam int COORD_W = 24;
  localparam int POS_W   = 26;
  localparam int RAD_W   = 24;
  localparam int AMP_W   = 16;
  localparam int TIME_W  = 32;
  localparam int DISP_W  = 18;
  localparam int MAG_W   = 26;
  localparam int SQ_W    = 52;
  localparam int R2_W    = 48;
  localparam int Q_W     = 17;
  localparam int W_W     = 17;
  localparam int SIN_W   = 13;
  localparam int TERM_W  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd4;

  localparam logic [RAD_W-1:0] RADIUS_RESET    = 24'd14080;
  localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 16'd451;
  localparam logic [AMP_W-1:0] AMPLITUDE_DFLT  = 16'd451;
  localparam logic [RAD_W-1:0] RADIUS_DFLT_INT = 24'd55;

  // q16 scale factors for the second pole
  localparam logic [15:0] OFS_X_Q16 = 16'd27525;
  localparam logic [15:0] OFS_Z_Q16 = 16'd20093;
  localparam logic [15:0] RAD_Q16   = 16'd57672;
  localparam logic [15:0] AMP_Q16   = 16'd53740;

  localparam logic [31:0] PHASE_MUL0 = 32'd922813121;
  localparam logic [31:0] PHASE_OFS0 = 32'd0;
  localparam logic [31:0] PHASE_MUL1 = 32'd1107375745;
  localparam logic [31:0] PHASE_OFS1 = 32'd1483336620;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] pz;
    logic [RAD_W-1:0]        r;
    logic [AMP_W-1:0]        amp;
  } pole_t;

  typedef struct packed {
    logic  active;
    pole_t p0;
    pole_t p1;
  } cfg_t;

  // quarter-wave sine entry, q12, from a short taylor series in q30
  function automatic logic [SIN_W-1:0] sine_entry(input int bits, input int i);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned r;
    longint unsigned v;
    a  = (longint'(i) * HALF_PI_Q30) >> bits;
    a2 = (a * a) >> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - ((a2 * r) >> 30) / 156;
    r  = ONE_Q30 - ((a2 * r) >> 30) / 110;
    r  = ONE_Q30 - ((a2 * r) >> 30) / 72;
    r  = ONE_Q30 - ((a2 * r) >> 30) / 42;
    r  = ONE_Q30 - ((a2 * r) >> 30) / 20;
    r  = ONE_Q30 - ((a2 * r) >> 30) / 6;
    v  = (((a * r) >> 30) + (64'd1 << 17)) >> 18;
    return v[SIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wpd_if.sv =====
// ----------------------------------------------------------------------------
// wpd stream interfaces
// Valid/ready channels for sample points and displacement results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wpd_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [23:0]          world_x;
  logic signed [23:0]          world_z;
  logic [31:0]                 time_now;
  modport source (output valid, world_x, world_z, time_now, input ready);
  modport sink   (input valid, world_x, world_z, time_now, output ready);
endinterface

interface wpd_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [17:0]          displacement;
  modport source (output valid, displacement, input ready);
  modport sink   (input valid, displacement, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wpd_cfg.sv =====
// ----------------------------------------------------------------------------
// wpd_cfg
// Configuration registers and the derived per-pole geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpd_cfg #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [wpd_pkg::CFG_IDX_W-1:0]     index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]    data,
  output wpd_pkg::cfg_t                     cfg
);
  import wpd_pkg::*;

  localparam logic [RAD_W-1:0] RAD_ONE  = RAD_W'(1) << COORD_FRAC_BITS;
  localparam logic [RAD_W-1:0] RAD_DFLT = RADIUS_DFLT_INT << COORD_FRAC_BITS;

  logic                      active;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0]          wave_radius;
  logic [AMP_W-1:0]          wave_amplitude;

  logic [RAD_W-1:0] rad;
  logic [AMP_W-1:0] amp;
  logic [RAD_W+15:0] ox_prod, oz_prod, r_prod;
  logic [AMP_W+15:0] a_prod;
  pole_t p0, p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      center_x       <= '0;
      center_z       <= '0;
      wave_radius    <= RADIUS_RESET;
      wave_amplitude <= AMPLITUDE_RESET;
    end else if (we) begin
      case (index)
        CFG_ACTIVE:    active         <= data[0];
        CFG_CENTER_X:  center_x       <= data;
        CFG_CENTER_Z:  center_z       <= data;
        CFG_RADIUS:    wave_radius    <= data;
        CFG_AMPLITUDE: wave_amplitude <= data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rad     = (wave_radius > RAD_ONE) ? wave_radius : RAD_DFLT;
    amp     = (wave_amplitude != '0) ? wave_amplitude : AMPLITUDE_DFLT;
    ox_prod = rad * OFS_X_Q16 + (RAD_W+16)'(32768);
    oz_prod = rad * OFS_Z_Q16 + (RAD_W+16)'(32768);
    r_prod  = rad * RAD_Q16 + (RAD_W+16)'(32768);
    a_prod  = amp * AMP_Q16 + (AMP_W+16)'(32768);
  end

  // derived values are registered from the configuration registers
  always_ff @(posedge clk) begin
    p0.px  <= POS_W'(center_x);
    p0.pz  <= POS_W'(center_z);
    p0.r   <= rad;
    p0.amp <= amp;
    p1.px  <= POS_W'(center_x) + POS_W'(ox_prod[RAD_W+15:16]);
    p1.pz  <= POS_W'(center_z) + POS_W'(oz_prod[RAD_W+15:16]);
    p1.r   <= r_prod[RAD_W+15:16];
    p1.amp <= a_prod[AMP_W+15:16];
  end

  assign cfg.active = active;
  assign cfg.p0     = p0;
  assign cfg.p1     = p1;

endmodule

`default_nettype wire

// ===== rtl/core/wpd_div.sv =====
// ----------------------------------------------------------------------------
// wpd_div
// Pipelined restoring divider, one quotient bit per stage, giving
// floor(rem * 2^16 / divisor) for rem not above divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpd_div #(
  parameter int SIDE_W = 33
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [wpd_pkg::R2_W-1:0]    rem,
  input  logic [wpd_pkg::R2_W-1:0]    divisor,
  input  logic [SIDE_W-1:0]           side,
  output logic                        out_valid,
  output logic [wpd_pkg::Q_W-1:0]     quo,
  output logic [SIDE_W-1:0]           side_out
);
  import wpd_pkg::*;

  logic              v_s   [Q_W+1];
  logic [R2_W-1:0]   rem_s [Q_W+1];
  logic [R2_W-1:0]   div_s [Q_W+1];
  logic [Q_W-1:0]    q_s   [Q_W+1];
  logic [SIDE_W-1:0] sd_s  [Q_W+1];

  assign v_s[0]   = in_valid;
  assign rem_s[0] = rem;
  assign div_s[0] = divisor;
  assign q_s[0]   = '0;
  assign sd_s[0]  = side;

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic [R2_W:0] trial;
    logic          ge;
    if (j == 0) begin : g_first
      assign trial = {1'b0, rem_s[j]};
    end else begin : g_rest
      assign trial = {rem_s[j], 1'b0};
    end
    assign ge = trial >= {1'b0, div_s[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1] <= ge ? R2_W'(trial - {1'b0, div_s[j]}) : trial[R2_W-1:0];
        div_s[j+1] <= div_s[j];
        q_s[j+1]   <= {q_s[j][Q_W-2:0], ge};
        sd_s[j+1]  <= sd_s[j];
      end
    end
  end

  assign out_valid = v_s[Q_W];
  assign quo       = q_s[Q_W];
  assign side_out  = sd_s[Q_W];

endmodule

`default_nettype wire

// ===== rtl/core/wpd_pole.sv =====
// ----------------------------------------------------------------------------
// wpd_pole
// One wave pole: distance, falloff division, phase and sine lookup, and the
// scaled term, as a stall-together pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpd_pole #(
  parameter int          SINE_TABLE_BITS = 10,
  parameter logic [31:0] PHASE_MUL       = 32'd922813121,
  parameter logic [31:0] PHASE_OFS       = 32'd0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [wpd_pkg::COORD_W-1:0]  wx,
  input  logic signed [wpd_pkg::COORD_W-1:0]  wz,
  input  logic [wpd_pkg::TIME_W-1:0]          tm,
  input  wpd_pkg::pole_t                      pole,
  output logic                                out_valid,
  output logic signed [wpd_pkg::TERM_W-1:0]   term
);
  import wpd_pkg::*;

  localparam int QN     = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W = SINE_TABLE_BITS + 1;
  localparam int SIDE_W = TIME_W + 1;

  logic [SIN_W-1:0] qtab [QN+1];
  for (genvar gi = 0; gi <= QN; gi++) begin : g_tab
    localparam logic [SIN_W-1:0] V = sine_entry(SINE_TABLE_BITS, gi);
    assign qtab[gi] = V;
  end

  // stage 1: offsets and time product
  logic signed [POS_W:0] dx, dz;
  logic [MAG_W-1:0] mag_x, mag_z;
  logic [63:0]      prod;
  logic             v1;

  assign dx = (POS_W+1)'(wx) - (POS_W+1)'(pole.px);
  assign dz = (POS_W+1)'(wz) - (POS_W+1)'(pole.pz);

  // stage 2: squares and phase
  logic [SQ_W-1:0]   sqx, sqz;
  logic [R2_W-1:0]   r2;
  logic [TIME_W-1:0] ph2;
  logic              v2;

  // stage 3: distance test and remainder
  logic [SQ_W:0]     d2;
  logic [R2_W-1:0]   rem3, r2_3;
  logic [TIME_W-1:0] ph3;
  logic              in3, v3;

  assign d2 = {1'b0, sqx} + {1'b0, sqz};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x <= dx[POS_W] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_z <= dz[POS_W] ? MAG_W'(-dz) : MAG_W'(dz);
      prod  <= 64'(tm) * 64'(PHASE_MUL);
      sqx   <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sqz   <= SQ_W'(mag_z) * SQ_W'(mag_z);
      r2    <= R2_W'(pole.r) * R2_W'(pole.r);
      ph2   <= prod[47:16] + PHASE_OFS;
      in3   <= d2 < (SQ_W+1)'(r2);
      rem3  <= r2 - d2[R2_W-1:0];
      r2_3  <= r2;
      ph3   <= ph2;
    end
  end

  logic              vd;
  logic [Q_W-1:0]    t_q;
  logic [SIDE_W-1:0] sd;

  wpd_div #(.SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .rem       (rem3),
    .divisor   (r2_3),
    .side      ({in3, ph3}),
    .out_valid (vd),
    .quo       (t_q),
    .side_out  (sd)
  );

  // falloff square and sine lookup
  logic [2*Q_W-1:0]  tt;
  logic [ADDR_W-1:0] idx, addr;
  logic [1:0]        quad;
  logic [W_W-1:0]    w_w;
  logic [SIN_W-1:0]  sv_w;
  logic              neg_w, in_w, v_w;

  assign tt   = ((2*Q_W)'(t_q) * (2*Q_W)'(t_q)) + (2*Q_W)'(32768);
  assign quad = sd[TIME_W-1 -: 2];
  assign idx  = ADDR_W'(sd[TIME_W-3 -: SINE_TABLE_BITS]);
  assign addr = quad[0] ? ADDR_W'(QN) - idx : idx;

  // amplitude and sine products
  logic [W_W+AMP_W-1:0]       m1;
  logic [SIN_W-1:0]           sv_m;
  logic                       neg_m, in_m, v_m;
  logic [W_W+AMP_W+SIN_W-1:0] mag;
  logic                       neg_g, in_g, v_g;
  logic [W_W+AMP_W+SIN_W-1:0] rnd;
  logic [TERM_W-1:0]          qmag;

  assign rnd  = mag + (W_W+AMP_W+SIN_W)'(1 << 27);
  assign qmag = TERM_W'(rnd >> 28);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_w       <= 1'b0;
      v_m       <= 1'b0;
      v_g       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_w       <= vd;
      v_m       <= v_w;
      v_g       <= v_m;
      out_valid <= v_g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_w   <= tt[W_W+15:16];
      sv_w  <= qtab[addr];
      neg_w <= quad[1];
      in_w  <= sd[TIME_W];
      m1    <= (W_W+AMP_W)'(w_w) * (W_W+AMP_W)'(pole.amp);
      sv_m  <= sv_w;
      neg_m <= neg_w;
      in_m  <= in_w;
      mag   <= (W_W+AMP_W+SIN_W)'(m1) * (W_W+AMP_W+SIN_W)'(sv_m);
      neg_g <= neg_m;
      in_g  <= in_m;
      if (!in_g) begin
        term <= '0;
      end else if (neg_g) begin
        term <= -$signed(qmag);
      end else begin
        term <= $signed(qmag);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/two_pole_wave_displacement.sv =====
// ----------------------------------------------------------------------------
// two_pole_wave_displacement
// Water height displacement from two moving wave poles around a center.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries a point (world_x, world_z, Q15.8) and time_now (Q16.16 s);
//   result carries displacement (Q5.12, saturated) for each sample, in order.
//   Registers are written through cfg_we / cfg_index / cfg_data while the
//   block is idle: 0 active, 1 center_x, 2 center_z, 3 radius, 4 amplitude.
//   Throughput is one transaction per cycle while result is not stalled. A
//   sample passes the input register, distance and phase stages, the
//   17-stage falloff divider, sine table, product and output stages.
//   The whole pipeline advances together: when result is stalled with a
//   valid item, sample.ready drops and every stage holds, so nothing is lost
//   or repeated. Reset clears all valid bits and restores the register
//   defaults (inactive, center 0, radius 55.0, amplitude 0.11); there is no
//   clearing pass, samples are taken the cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_pole_wave_displacement #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  wpd_in_if.sink                            sample,
  wpd_out_if.source                         result
);
  import wpd_pkg::*;

  localparam logic signed [TERM_W:0] SAT_HI = (TERM_W+1)'(131071);
  localparam logic signed [TERM_W:0] SAT_LO = -(TERM_W+1)'(131072);

  cfg_t cfg;
  logic en;
  logic res_valid;
  logic signed [DISP_W-1:0] disp;

  assign en           = !res_valid || result.ready;
  assign sample.ready = en && !rst;

  wpd_cfg #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // input register
  logic                      v0;
  logic signed [COORD_W-1:0] wx, wz;
  logic [TIME_W-1:0]         tm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= sample.world_x;
      wz <= sample.world_z;
      tm <= sample.time_now;
    end
  end

  logic                     pv0, pv1;
  logic signed [TERM_W-1:0] term0, term1;

  wpd_pole #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_MUL       (PHASE_MUL0),
    .PHASE_OFS       (PHASE_OFS0)
  ) u_pole0 (
    .clk (clk), .rst (rst), .en (en), .in_valid (v0),
    .wx (wx), .wz (wz), .tm (tm), .pole (cfg.p0),
    .out_valid (pv0), .term (term0)
  );

  wpd_pole #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_MUL       (PHASE_MUL1),
    .PHASE_OFS       (PHASE_OFS1)
  ) u_pole1 (
    .clk (clk), .rst (rst), .en (en), .in_valid (v0),
    .wx (wx), .wz (wz), .tm (tm), .pole (cfg.p1),
    .out_valid (pv1), .term (term1)
  );

  logic signed [TERM_W:0] sum;
  assign sum = (TERM_W+1)'(term0) + (TERM_W+1)'(term1);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= pv0 && pv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!cfg.active) begin
        disp <= '0;
      end else if (sum > SAT_HI) begin
        disp <= DISP_W'(SAT_HI);
      end else if (sum < SAT_LO) begin
        disp <= DISP_W'(SAT_LO);
      end else begin
        disp <= DISP_W'(sum);
      end
    end
  end

  assign result.valid        = res_valid;
  assign result.displacement = disp;

endmodule

`default_nettype wire
